### hw/rtl/cmpcal_pkg.sv
// Shared types, constants and arctangent table for the compass heading block.
`default_nettype none

package cmpcal_pkg;

   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned RANGE_W   = 17;
   localparam int unsigned DIFF_W    = 18;
   localparam int unsigned VEC_W     = 2 * DIFF_W;
   localparam int unsigned HEADING_W = 16;
   localparam int unsigned TABLE_LEN = 24;

   localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
      32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
   };

   typedef struct packed {
      logic valid;
      logic calibrated;
      logic zero_vec;
   } cmpcal_ctl_type;

   typedef struct packed {
      logic [HEADING_W-1:0] heading;
      logic                 calibrated;
   } cmpcal_rsp_type;

   // Rounds the arctangent of step i (2^32 per turn) half up to the angle width.
   function automatic logic [31:0] atan_step(input int unsigned step,
                                             input int unsigned angle_bits);
      int unsigned sh;
      sh = 32 - angle_bits;
      return (ATAN_TURN32[step] + (32'd1 << (sh - 1))) >> sh;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/cmpcal_if.sv
// Handshake channel interfaces for samples, results and the declination register.
`default_nettype none

interface cmpcal_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_sample;
   logic signed [15:0] y_sample;
   logic               clear_calibration;
   modport source(output valid, x_sample, y_sample, clear_calibration, input ready);
   modport sink(input valid, x_sample, y_sample, clear_calibration, output ready);
endinterface

interface cmpcal_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] heading;
   logic        calibrated;
   modport source(output valid, heading, calibrated, input ready);
   modport sink(input valid, heading, calibrated, output ready);
endinterface

interface cmpcal_csr_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] declination;
   modport source(output valid, declination, input ready);
   modport sink(input valid, declination, output ready);
endinterface

`default_nettype wire

### hw/rtl/cmpcal_track.sv
// Min/max calibration tracker with centering and range stage.
`default_nettype none

module cmpcal_track (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic                                  take,
   input  wire logic signed [cmpcal_pkg::SAMPLE_W-1:0] x_sample,
   input  wire logic signed [cmpcal_pkg::SAMPLE_W-1:0] y_sample,
   input  wire logic                                  clear_calibration,
   output cmpcal_pkg::cmpcal_ctl_type                 ctl,
   output logic signed [cmpcal_pkg::DIFF_W-1:0]       xc2,
   output logic signed [cmpcal_pkg::DIFF_W-1:0]       yc2,
   output logic [cmpcal_pkg::RANGE_W-1:0]             rx,
   output logic [cmpcal_pkg::RANGE_W-1:0]             ry
);
   import cmpcal_pkg::*;

   logic signed [SAMPLE_W-1:0] x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic signed [SAMPLE_W-1:0] x_low_in, x_high_in, y_low_in, y_high_in;
   logic [RANGE_W-1:0]         rx_ff, ry_ff, rx_in, ry_in;
   logic signed [DIFF_W-1:0]   xc2_ff, yc2_ff, xc2_in, yc2_in;
   cmpcal_ctl_type             ctl_ff, ctl_in;

   always_comb begin
      x_low_in  = x_low_ff;
      x_high_in = x_high_ff;
      y_low_in  = y_low_ff;
      y_high_in = y_high_ff;
      if (clear_calibration) begin
         x_low_in  = '0;
         x_high_in = '0;
         y_low_in  = '0;
         y_high_in = '0;
      end else begin
         if (x_sample < x_low_ff) begin
            x_low_in = x_sample;
         end else if (x_sample > x_high_ff) begin
            x_high_in = x_sample;
         end
         if (y_sample < y_low_ff) begin
            y_low_in = y_sample;
         end else if (y_sample > y_high_ff) begin
            y_high_in = y_sample;
         end
      end
      rx_in = RANGE_W'({x_high_in[SAMPLE_W-1], x_high_in} - {x_low_in[SAMPLE_W-1], x_low_in});
      ry_in = RANGE_W'({y_high_in[SAMPLE_W-1], y_high_in} - {y_low_in[SAMPLE_W-1], y_low_in});
      xc2_in = {x_sample[SAMPLE_W-1], x_sample, 1'b0}
               - ({{2{x_high_in[SAMPLE_W-1]}}, x_high_in} + {{2{x_low_in[SAMPLE_W-1]}}, x_low_in});
      yc2_in = {y_sample[SAMPLE_W-1], y_sample, 1'b0}
               - ({{2{y_high_in[SAMPLE_W-1]}}, y_high_in} + {{2{y_low_in[SAMPLE_W-1]}}, y_low_in});
      ctl_in.valid      = take;
      ctl_in.calibrated = !clear_calibration && (rx_in != '0) && (ry_in != '0);
      ctl_in.zero_vec   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff  <= '0;
         x_high_ff <= '0;
         y_low_ff  <= '0;
         y_high_ff <= '0;
      end else if (take) begin
         x_low_ff  <= x_low_in;
         x_high_ff <= x_high_in;
         y_low_ff  <= y_low_in;
         y_high_ff <= y_high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         xc2_ff <= xc2_in;
         yc2_ff <= yc2_in;
      end
   end

   assign ctl = ctl_ff;
   assign xc2 = xc2_ff;
   assign yc2 = yc2_ff;
   assign rx  = rx_ff;
   assign ry  = ry_ff;

endmodule

`default_nettype wire

### hw/rtl/cmpcal_cell.sv
// One registered CORDIC vectoring cell of the arctangent chain.
`default_nettype none

module cmpcal_cell #(
   parameter int unsigned STEP       = 0,
   parameter int unsigned ANGLE_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire cmpcal_pkg::cmpcal_ctl_type          up_ctl,
   input  wire logic signed [cmpcal_pkg::VEC_W-1:0] up_x,
   input  wire logic signed [cmpcal_pkg::VEC_W-1:0] up_y,
   input  wire logic [ANGLE_BITS-1:0]               up_z,
   output cmpcal_pkg::cmpcal_ctl_type               dn_ctl,
   output logic signed [cmpcal_pkg::VEC_W-1:0]      dn_x,
   output logic signed [cmpcal_pkg::VEC_W-1:0]      dn_y,
   output logic [ANGLE_BITS-1:0]                    dn_z
);
   import cmpcal_pkg::*;

   localparam logic [ANGLE_BITS-1:0] ATAN = ANGLE_BITS'(atan_step(STEP, ANGLE_BITS));

   cmpcal_ctl_type          ctl_ff;
   logic signed [VEC_W-1:0] x_ff, y_ff, x_in, y_in;
   logic [ANGLE_BITS-1:0]   z_ff, z_in;

   always_comb begin
      if (!up_y[VEC_W-1]) begin
         x_in = up_x + (up_y >>> STEP);
         y_in = up_y - (up_x >>> STEP);
         z_in = up_z + ATAN;
      end else begin
         x_in = up_x - (up_y >>> STEP);
         y_in = up_y + (up_x >>> STEP);
         z_in = up_z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_x   = x_ff;
   assign dn_y   = y_ff;
   assign dn_z   = z_ff;

endmodule

`default_nettype wire

### hw/rtl/cmpcal_outbuf.sv
// Two-entry result buffer that decouples the pipeline from the result channel.
`default_nettype none

module cmpcal_outbuf (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire cmpcal_pkg::cmpcal_rsp_type push_data,
   output logic                            space,
   input  wire logic                       pop_ready,
   output logic                            out_valid,
   output cmpcal_pkg::cmpcal_rsp_type      out_data
);
   import cmpcal_pkg::*;

   cmpcal_rsp_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign space     = (count_ff != 2'd2);
   assign pop       = out_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/compass_heading_minmax_cal.sv
// Top level of the min/max calibrated compass heading block with a CORDIC cell chain.
// Path: a sample passes the tracker register, the scaling and quadrant registers, the cell chain and the result buffer.
// Throughput: one sample per cycle while not stalled, set by the min/max update and the unrolled cell chain.
// The pipeline stalls only while both entries of the two-entry result buffer are full.
// Reset clears all min/max state, the declination register and every valid bit.
`default_nettype none

module compass_heading_minmax_cal #(
   parameter int unsigned CORDIC_STEPS = 16,
   parameter int unsigned ANGLE_BITS   = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   cmpcal_req_if.sink   req,
   cmpcal_rsp_if.source rsp,
   cmpcal_csr_if.sink   csr
);
   import cmpcal_pkg::*;

   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   logic                     en, take;
   logic [HEADING_W-1:0]     decl_ff;
   cmpcal_ctl_type           s0_ctl;
   logic signed [DIFF_W-1:0] s0_xc2, s0_yc2;
   logic [RANGE_W-1:0]       s0_rx, s0_ry;

   cmpcal_ctl_type           p1_ctl_ff, p1_ctl_in;
   logic signed [VEC_W-1:0]  p1_x_ff, p1_y_ff, p1_x_in, p1_y_in;

   cmpcal_ctl_type           p2_ctl_ff;
   logic signed [VEC_W-1:0]  p2_x_ff, p2_y_ff, p2_x_in, p2_y_in;
   logic [ANGLE_BITS-1:0]    p2_z_ff, p2_z_in;

   cmpcal_ctl_type           c_ctl [CORDIC_STEPS+1];
   logic signed [VEC_W-1:0]  c_x [CORDIC_STEPS+1];
   logic signed [VEC_W-1:0]  c_y [CORDIC_STEPS+1];
   logic [ANGLE_BITS-1:0]    c_z [CORDIC_STEPS+1];

   logic [HEADING_W-1:0]     bam;
   cmpcal_rsp_type           fin_data, ob_data;
   logic                     ob_space, ob_valid;

   assign req.ready = en;
   assign take      = req.valid && en;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= '0;
      end else if (csr.valid) begin
         decl_ff <= HEADING_W'(csr.declination);
      end
   end

   cmpcal_track u_track (
      .clock             (clock),
      .reset             (reset),
      .en                (en),
      .take              (take),
      .x_sample          (req.x_sample),
      .y_sample          (req.y_sample),
      .clear_calibration (req.clear_calibration),
      .ctl               (s0_ctl),
      .xc2               (s0_xc2),
      .yc2               (s0_yc2),
      .rx                (s0_rx),
      .ry                (s0_ry)
   );

   always_comb begin
      p1_x_in = VEC_W'(s0_xc2) * VEC_W'($signed({1'b0, s0_ry}));
      p1_y_in = VEC_W'(s0_yc2) * VEC_W'($signed({1'b0, s0_rx}));
      p1_ctl_in          = s0_ctl;
      p1_ctl_in.zero_vec = (s0_xc2 == '0) && (s0_yc2 == '0);
   end

   always_comb begin
      p2_x_in = p1_x_ff;
      p2_y_in = p1_y_ff;
      p2_z_in = '0;
      if (p1_x_ff[VEC_W-1]) begin
         if (!p1_y_ff[VEC_W-1]) begin
            p2_x_in = p1_y_ff;
            p2_y_in = -p1_x_ff;
            p2_z_in = QUARTER;
         end else begin
            p2_x_in = -p1_y_ff;
            p2_y_in = p1_x_ff;
            p2_z_in = '0 - QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ctl_ff <= '0;
         p2_ctl_ff <= '0;
      end else if (en) begin
         p1_ctl_ff <= p1_ctl_in;
         p2_ctl_ff <= p1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_x_ff <= p1_x_in;
         p1_y_ff <= p1_y_in;
         p2_x_ff <= p2_x_in;
         p2_y_ff <= p2_y_in;
         p2_z_ff <= p2_z_in;
      end
   end

   assign c_ctl[0] = p2_ctl_ff;
   assign c_x[0]   = p2_x_ff;
   assign c_y[0]   = p2_y_ff;
   assign c_z[0]   = p2_z_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      cmpcal_cell #(
         .STEP       (i),
         .ANGLE_BITS (ANGLE_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .up_ctl (c_ctl[i]),
         .up_x   (c_x[i]),
         .up_y   (c_y[i]),
         .up_z   (c_z[i]),
         .dn_ctl (c_ctl[i+1]),
         .dn_x   (c_x[i+1]),
         .dn_y   (c_y[i+1]),
         .dn_z   (c_z[i+1])
      );
   end

   if (ANGLE_BITS > HEADING_W) begin : g_round
      localparam int unsigned SH = ANGLE_BITS - HEADING_W;
      logic [ANGLE_BITS:0] rnd;
      assign rnd = {1'b0, c_z[CORDIC_STEPS]} + ((ANGLE_BITS + 1)'(1) << (SH - 1));
      assign bam = rnd[SH+HEADING_W-1:SH];
   end else begin : g_widen
      assign bam = HEADING_W'(c_z[CORDIC_STEPS]) << (HEADING_W - ANGLE_BITS);
   end

   always_comb begin
      fin_data.calibrated = c_ctl[CORDIC_STEPS].calibrated;
      if (!c_ctl[CORDIC_STEPS].calibrated) begin
         fin_data.heading = '0;
      end else if (c_ctl[CORDIC_STEPS].zero_vec) begin
         fin_data.heading = decl_ff;
      end else begin
         fin_data.heading = bam + decl_ff;
      end
   end

   cmpcal_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (en && c_ctl[CORDIC_STEPS].valid),
      .push_data (fin_data),
      .space     (ob_space),
      .pop_ready (rsp.ready),
      .out_valid (ob_valid),
      .out_data  (ob_data)
   );

   assign en             = ob_space;
   assign rsp.valid      = ob_valid;
   assign rsp.heading    = ob_data.heading;
   assign rsp.calibrated = ob_data.calibrated;

   a_uncal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.calibrated) |-> (rsp.heading == '0))
      else $error("Uncalibrated result carries a nonzero heading.");

   a_clear_uncal: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.clear_calibration) |=> (s0_ctl.valid && !s0_ctl.calibrated))
      else $error("Clear transfer did not produce an uncalibrated stage entry.");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid)
      else $error("Input stalled while no result is waiting.");

endmodule

`default_nettype wire
